@@ hdl/rpr_pkg.sv @@
// ============================================================================
// rpr_pkg - shared constants, types and table functions
// Holds the register codes, the CORDIC angle table and the 2^-(2^-k) roots.
// ============================================================================
`default_nettype none

package rpr_pkg;

    // token position bits that take part in the angle
    localparam int POSITION_BITS = 20;

    // configuration register codes and reset values
    localparam logic [1:0] CFG_LOG2_BASE = 2'd0;
    localparam logic [1:0] CFG_VEC_LEN   = 2'd1;
    localparam logic [1:0] CFG_ROPE_EN   = 2'd2;

    localparam logic [21:0] RST_LOG2_BASE = 22'd870805;
    localparam logic [8:0]  RST_VEC_LEN   = 9'd128;
    localparam logic        RST_ROPE_EN   = 1'b1;

    // CORDIC datapath
    localparam int CORDIC_ITERS = 24;
    localparam int CORDIC_XW    = 34;
    localparam int CORDIC_ZW    = 33;
    localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
    localparam logic [61:0] INV_TWO_PI_Q64 = 62'h28BE60DB9391054A;

    localparam logic [31:0] ATAN_Q30 [0:10] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576
    };

    // side data that rides along the CORDIC stages
    typedef struct packed {
        logic [15:0] x_half;
        logic [15:0] y_half;
        logic [1:0]  quad;
    } t_side;

    // arctangent of 2^-k in Q.30
    function automatic logic [31:0] cordic_atan(input int k);
        logic [31:0] v;
        if (k < 11) begin
            v = ATAN_Q30[k];
        end else begin
            v = 32'd1 << (30 - k);
        end
        return v;
    endfunction

    // floor square root, bit by bit
    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        x = v;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^-(2^-k) in Q0.32, from repeated square roots of one half
    function automatic logic [31:0] exp_root(input int k);
        longint unsigned c;
        c = 64'h8000_0000;
        for (int j = 1; j <= k; j++) begin
            c = isqrt64(c << 32);
        end
        return c[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/rpr_cordic.sv @@
// ============================================================================
// rpr_cordic - pipelined rotation-mode CORDIC
// One iteration per register stage; side data travels with each beat.
// ============================================================================
`default_nettype none

module rpr_cordic (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_ce,
    input  wire logic                                       i_valid,
    input  wire logic signed [rpr_pkg::CORDIC_ZW-1:0]       i_z,
    input  wire rpr_pkg::t_side                             i_side,
    output logic                                            o_valid,
    output logic signed [rpr_pkg::CORDIC_XW-1:0]            o_x,
    output logic signed [rpr_pkg::CORDIC_XW-1:0]            o_y,
    output rpr_pkg::t_side                                  o_side
);

    localparam int N  = rpr_pkg::CORDIC_ITERS;
    localparam int XW = rpr_pkg::CORDIC_XW;
    localparam int ZW = rpr_pkg::CORDIC_ZW;

    logic                 w_v    [0:N];
    logic signed [XW-1:0] w_x    [0:N];
    logic signed [XW-1:0] w_y    [0:N];
    logic signed [ZW-1:0] w_z    [0:N-1];
    rpr_pkg::t_side       w_side [0:N];

    assign w_v[0]    = i_valid;
    assign w_x[0]    = rpr_pkg::CORDIC_GAIN;
    assign w_y[0]    = '0;
    assign w_z[0]    = i_z;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < N; k++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = $signed({1'b0, rpr_pkg::cordic_atan(k)});

        logic                 r_v;
        logic signed [XW-1:0] r_x;
        logic signed [XW-1:0] r_y;
        rpr_pkg::t_side       r_side;
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;
        logic                 w_neg;

        assign w_dx  = w_y[k] >>> k;
        assign w_dy  = w_x[k] >>> k;
        assign w_neg = w_z[k][ZW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_ce) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_side <= w_side[k];
                if (!w_neg) begin
                    r_x <= w_x[k] - w_dx;
                    r_y <= w_y[k] + w_dy;
                end else begin
                    r_x <= w_x[k] + w_dx;
                    r_y <= w_y[k] - w_dy;
                end
            end
        end

        // the last iteration leaves no residual angle behind
        if (k < N - 1) begin : g_z
            logic signed [ZW-1:0] r_z;
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_z <= w_neg ? (w_z[k] + ATAN) : (w_z[k] - ATAN);
                end
            end
            assign w_z[k+1] = r_z;
        end

        assign w_v[k+1]    = r_v;
        assign w_x[k+1]    = r_x;
        assign w_y[k+1]    = r_y;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[N];
    assign o_x     = w_x[N];
    assign o_y     = w_y[N];
    assign o_side  = w_side[N];

endmodule

`default_nettype wire

@@ hdl/rope_pair_rotator.sv @@
// ============================================================================
// rope_pair_rotator - NEOX rotary embedding of one element pair per beat
// Frequency exponent by pipelined division, 2^-f by a chain of root
// multiplies, turn fraction by a split 53x62 product, sin/cos by CORDIC.
// ============================================================================
//
//  channel  | dir | fields (lowest bit first)
//  ---------+-----+---------------------------------------------------------
//  s (in)   | in  | first_half 16, second_half 16, pair_index 7, position 20
//  m (out)  | out | tdata: rotated_first 32, rotated_second 32; tuser: saturated
//  cfg      | in  | idx 0 log2_base 22, idx 1 vec_len 9, idx 2 rope_enabled 1
//
//  One beat enters per cycle while the output is not stalled. The longest stage
//  runs are the 30-step divider, 16 root multiplies and 24 CORDIC iterations.
//  The whole pipeline advances together whenever the output register is empty
//  or being taken; a stalled output freezes every stage, so nothing is lost.
//  Reset clears the valid bits and loads the register defaults; no clearing pass.
// ============================================================================
`default_nettype none

module rope_pair_rotator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // first_half[15:0], second_half[31:16], pair_index[38:32], position[58:39]
    input  wire logic [63:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // rotated_first[31:0], rotated_second[63:32]
    output logic [63:0]      o_m_tdata,
    // saturated[0]
    output logic             o_m_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [21:0] i_cfg_data
);

    localparam int POS_W  = rpr_pkg::POSITION_BITS;
    localparam int NUM_W  = 30;
    localparam int DIV_W  = 9;
    localparam int FRAC_W = 16;
    localparam int N_W    = NUM_W - FRAC_W;
    localparam int M_W    = 33;
    localparam int PROD_W = POS_W + M_W;
    localparam int XW     = rpr_pkg::CORDIC_XW;
    localparam int CS_W   = XW - 8;
    localparam int TERM_W = 66;

    localparam logic [4:0] FP_EXP_MAX = 5'h1F;
    localparam logic [5:0] FP_SH_INF  = 6'd39;

    typedef struct packed {
        logic [15:0]      x_half;
        logic [15:0]      y_half;
        logic [POS_W-1:0] pos;
    } t_pay;

    typedef struct packed {
        logic        sign;
        logic [10:0] mant;
        logic [5:0]  sh;
    } t_fp;

    function automatic t_fp fp16_decode(input logic [15:0] h);
        t_fp d;
        d.sign = h[15];
        if (h[14:10] == 5'd0) begin
            d.mant = {1'b0, h[9:0]};
            d.sh   = 6'd0;
        end else if (h[14:10] == FP_EXP_MAX) begin
            d.mant = 11'd1;
            d.sh   = FP_SH_INF;
        end else begin
            d.mant = {1'b1, h[9:0]};
            d.sh   = {1'b0, h[14:10]} - 6'd1;
        end
        return d;
    endfunction

    function automatic logic signed [TERM_W-1:0] scale_term(
        input logic signed [37:0] p, input logic [5:0] sh, input logic neg);
        logic signed [TERM_W-1:0] v;
        v = TERM_W'(p) <<< sh;
        return neg ? -v : v;
    endfunction

    // ---------------------------------------------------------------- config
    logic [21:0] r_log2_base;
    logic [8:0]  r_vec_len;
    logic        r_rope_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_base <= rpr_pkg::RST_LOG2_BASE;
            r_vec_len   <= rpr_pkg::RST_VEC_LEN;
            r_rope_en   <= rpr_pkg::RST_ROPE_EN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rpr_pkg::CFG_LOG2_BASE: r_log2_base <= i_cfg_data;
                rpr_pkg::CFG_VEC_LEN:   r_vec_len   <= i_cfg_data[8:0];
                rpr_pkg::CFG_ROPE_EN:   r_rope_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow
    logic r_out_valid;
    logic w_ce;

    assign w_ce       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_ce;

    // ---------------------------------------------------------------- entry
    logic             r_en_v;
    t_pay             r_en_pay;
    logic [NUM_W-1:0] r_en_num;
    t_pay             w_in_pay;
    logic [6:0]       w_in_idx;

    assign w_in_pay.x_half = i_s_tdata[15:0];
    assign w_in_pay.y_half = i_s_tdata[31:16];
    assign w_in_idx        = i_s_tdata[38:32];
    assign w_in_pay.pos    = i_s_tdata[39 +: POS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_v <= 1'b0;
        end else if (w_ce) begin
            r_en_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_en_pay <= w_in_pay;
            r_en_num <= NUM_W'({w_in_idx, 1'b0}) * NUM_W'(r_log2_base);
        end
    end

    // ---------------------------------------------------------------- divider
    // accumulator holds {remainder, numerator bits shifting out / quotient in}
    logic [DIV_W-1:0]       w_div;
    logic                   w_dv_v   [0:NUM_W];
    t_pay                   w_dv_pay [0:NUM_W];
    logic [DIV_W+NUM_W-1:0] w_dv_acc [0:NUM_W];

    assign w_div       = (r_vec_len == '0) ? DIV_W'(1) : r_vec_len;
    assign w_dv_v[0]   = r_en_v;
    assign w_dv_pay[0] = r_en_pay;
    assign w_dv_acc[0] = {{DIV_W{1'b0}}, r_en_num};

    for (genvar j = 0; j < NUM_W; j++) begin : g_div
        logic                   r_v;
        t_pay                   r_pay;
        logic [DIV_W+NUM_W-1:0] r_acc;
        logic [DIV_W:0]         w_trial;
        logic                   w_ge;
        logic [DIV_W-1:0]       w_rem;

        assign w_trial = w_dv_acc[j][DIV_W+NUM_W-1 -: DIV_W+1];
        assign w_ge    = w_trial >= {1'b0, w_div};
        assign w_rem   = w_ge ? DIV_W'(w_trial - {1'b0, w_div}) : w_trial[DIV_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_ce) begin
                r_v <= w_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_pay <= w_dv_pay[j];
                r_acc <= {w_rem, w_dv_acc[j][NUM_W-2:0], w_ge};
            end
        end

        assign w_dv_v[j+1]   = r_v;
        assign w_dv_pay[j+1] = r_pay;
        assign w_dv_acc[j+1] = r_acc;
    end

    // ---------------------------------------------------------------- 2^-f
    logic              w_ex_v   [0:FRAC_W];
    t_pay              w_ex_pay [0:FRAC_W];
    logic [M_W-1:0]    w_ex_m   [0:FRAC_W];
    logic [FRAC_W-1:0] w_ex_f   [0:FRAC_W];
    logic [N_W-1:0]    w_ex_n   [0:FRAC_W];

    assign w_ex_v[0]   = w_dv_v[NUM_W];
    assign w_ex_pay[0] = w_dv_pay[NUM_W];
    assign w_ex_m[0]   = {1'b1, {(M_W-1){1'b0}}};
    assign w_ex_f[0]   = w_dv_acc[NUM_W][FRAC_W-1:0];
    assign w_ex_n[0]   = w_dv_acc[NUM_W][NUM_W-1:FRAC_W];

    for (genvar g = 0; g < FRAC_W; g++) begin : g_exp
        localparam logic [31:0] ROOT = rpr_pkg::exp_root(g + 1);

        logic              r_v;
        t_pay              r_pay;
        logic [M_W-1:0]    r_m;
        logic [FRAC_W-1:0] r_f;
        logic [N_W-1:0]    r_n;
        logic [M_W+31:0]   w_prod;

        // round half up back to Q1.32
        assign w_prod = ({32'd0, w_ex_m[g]} * {{M_W{1'b0}}, ROOT})
                      + {{M_W{1'b0}}, 32'h8000_0000};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_ce) begin
                r_v <= w_ex_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_pay <= w_ex_pay[g];
                r_f   <= w_ex_f[g];
                r_n   <= w_ex_n[g];
                r_m   <= w_ex_f[g][FRAC_W-1-g] ? w_prod[M_W+31:32] : w_ex_m[g];
            end
        end

        assign w_ex_v[g+1]   = r_v;
        assign w_ex_pay[g+1] = r_pay;
        assign w_ex_m[g+1]   = r_m;
        assign w_ex_f[g+1]   = r_f;
        assign w_ex_n[g+1]   = r_n;
    end

    // ---------------------------------------------------------------- turns
    logic              r_p0_v, r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    t_pay              r_p0_pay, r_p1_pay, r_p2_pay, r_p3_pay, r_p4_pay;
    logic [N_W-1:0]    r_p0_n, r_p1_n, r_p2_n, r_p3_n;
    logic [PROD_W-1:0] r_p0_prod;
    logic [57:0]       r_pp00, r_pp01;
    logic [56:0]       r_pp10, r_pp11;
    logic [88:0]       r_slo;
    logic [87:0]       r_shi;
    logic [50:0]       r_hi;
    logic [31:0]       r_turn;
    logic [114:0]      w_full;
    logic [50:0]       w_hi_sh;

    assign w_full  = {26'd0, r_slo} + {r_shi, 27'd0};
    assign w_hi_sh = r_hi >> r_p3_n[5:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else if (w_ce) begin
            r_p0_v <= w_ex_v[FRAC_W];
            r_p1_v <= r_p0_v;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_p0_pay  <= w_ex_pay[FRAC_W];
            r_p0_n    <= w_ex_n[FRAC_W];
            r_p0_prod <= {{M_W{1'b0}}, w_ex_pay[FRAC_W].pos}
                       * {{POS_W{1'b0}}, w_ex_m[FRAC_W]};

            // split 53x62 product into four partials
            r_p1_pay <= r_p0_pay;
            r_p1_n   <= r_p0_n;
            r_pp00   <= {31'd0, r_p0_prod[26:0]}  * {27'd0, rpr_pkg::INV_TWO_PI_Q64[30:0]};
            r_pp01   <= {31'd0, r_p0_prod[26:0]}  * {27'd0, rpr_pkg::INV_TWO_PI_Q64[61:31]};
            r_pp10   <= {31'd0, r_p0_prod[52:27]} * {26'd0, rpr_pkg::INV_TWO_PI_Q64[30:0]};
            r_pp11   <= {31'd0, r_p0_prod[52:27]} * {26'd0, rpr_pkg::INV_TWO_PI_Q64[61:31]};

            r_p2_pay <= r_p1_pay;
            r_p2_n   <= r_p1_n;
            r_slo    <= {31'd0, r_pp00} + {r_pp01, 31'd0};
            r_shi    <= {31'd0, r_pp10} + {r_pp11, 31'd0};

            r_p3_pay <= r_p2_pay;
            r_p3_n   <= r_p2_n;
            r_hi     <= w_full[114:64];

            // exponents of 64 and beyond push every turn bit out
            r_p4_pay <= r_p3_pay;
            r_turn   <= (r_p3_n[N_W-1:6] == '0) ? w_hi_sh[31:0] : 32'd0;
        end
    end

    // ---------------------------------------------------------------- angle
    logic                                 r_z_v;
    logic signed [rpr_pkg::CORDIC_ZW-1:0] r_z_z;
    rpr_pkg::t_side                       r_z_side;
    logic [60:0]                          w_zp;

    assign w_zp = {31'd0, r_turn[29:0]} * {30'd0, rpr_pkg::HALF_PI_Q30};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_v <= 1'b0;
        end else if (w_ce) begin
            r_z_v <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_z_z           <= {2'b00, w_zp[60:30]};
            r_z_side.x_half <= r_p4_pay.x_half;
            r_z_side.y_half <= r_p4_pay.y_half;
            r_z_side.quad   <= r_turn[31:30];
        end
    end

    logic                 w_co_v;
    logic signed [XW-1:0] w_co_x;
    logic signed [XW-1:0] w_co_y;
    rpr_pkg::t_side       w_co_side;

    rpr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_z_v),
        .i_z     (r_z_z),
        .i_side  (r_z_side),
        .o_valid (w_co_v),
        .o_x     (w_co_x),
        .o_y     (w_co_y),
        .o_side  (w_co_side)
    );

    // ---------------------------------------------------------------- rotate
    logic signed [CS_W-1:0] w_c, w_s, n_cs, n_sn;
    logic signed [CS_W-1:0] r_m0_cs, r_m0_sn;
    logic                   r_m0_v, r_m1_v, r_m2_v;
    t_fp                    r_m0_fx, r_m0_fy, r_m1_fx, r_m1_fy;
    logic signed [37:0]     r_xc, r_ys, r_yc, r_xs;
    logic signed [TERM_W-1:0] r_txc, r_tys, r_tyc, r_txs;

    assign w_c = w_co_x[XW-1:8];
    assign w_s = w_co_y[XW-1:8];

    always_comb begin
        unique case (w_co_side.quad)
            2'd0: begin n_cs = w_c;  n_sn = w_s;  end
            2'd1: begin n_cs = -w_s; n_sn = w_c;  end
            2'd2: begin n_cs = -w_c; n_sn = -w_s; end
            2'd3: begin n_cs = w_s;  n_sn = -w_c; end
            default: begin n_cs = w_c; n_sn = w_s; end
        endcase
        // unit cosine turns the rotation into a plain Q.24 to Q.16 conversion
        if (!r_rope_en) begin
            n_cs = CS_W'(1) <<< 22;
            n_sn = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_v <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
        end else if (w_ce) begin
            r_m0_v <= w_co_v;
            r_m1_v <= r_m0_v;
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m0_cs <= n_cs;
            r_m0_sn <= n_sn;
            r_m0_fx <= fp16_decode(w_co_side.x_half);
            r_m0_fy <= fp16_decode(w_co_side.y_half);

            r_m1_fx <= r_m0_fx;
            r_m1_fy <= r_m0_fy;
            r_xc    <= $signed({1'b0, r_m0_fx.mant}) * r_m0_cs;
            r_ys    <= $signed({1'b0, r_m0_fy.mant}) * r_m0_sn;
            r_yc    <= $signed({1'b0, r_m0_fy.mant}) * r_m0_cs;
            r_xs    <= $signed({1'b0, r_m0_fx.mant}) * r_m0_sn;

            r_txc <= scale_term(r_xc, r_m1_fx.sh, r_m1_fx.sign);
            r_tys <= scale_term(r_ys, r_m1_fy.sh, r_m1_fy.sign);
            r_tyc <= scale_term(r_yc, r_m1_fy.sh, r_m1_fy.sign);
            r_txs <= scale_term(r_xs, r_m1_fx.sh, r_m1_fx.sign);
        end
    end

    // ---------------------------------------------------------------- output
    logic signed [TERM_W:0] w_r0, w_r1;
    logic signed [36:0]     w_q0, w_q1;
    logic [31:0]            n_first, n_second;
    logic                   n_sat0, n_sat1;
    logic [31:0]            r_out_first, r_out_second;
    logic                   r_out_sat;

    assign w_r0 = {r_txc[TERM_W-1], r_txc} - {r_tys[TERM_W-1], r_tys}
                + ((TERM_W+1)'(1) <<< 29);
    assign w_r1 = {r_tyc[TERM_W-1], r_tyc} + {r_txs[TERM_W-1], r_txs}
                + ((TERM_W+1)'(1) <<< 29);
    assign w_q0 = w_r0[TERM_W:30];
    assign w_q1 = w_r1[TERM_W:30];

    always_comb begin
        n_sat0  = 1'b1;
        n_sat1  = 1'b1;
        n_first  = w_q0[31:0];
        n_second = w_q1[31:0];
        priority if (w_q0 > 37'sh0_7FFF_FFFF) n_first = 32'h7FFF_FFFF;
        else if (w_q0 < -37'sh0_8000_0000)    n_first = 32'h8000_0000;
        else                                  n_sat0  = 1'b0;
        priority if (w_q1 > 37'sh0_7FFF_FFFF) n_second = 32'h7FFF_FFFF;
        else if (w_q1 < -37'sh0_8000_0000)    n_second = 32'h8000_0000;
        else                                  n_sat1   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_out_valid <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_first  <= n_first;
            r_out_second <= n_second;
            r_out_sat    <= n_sat0 | n_sat1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_second, r_out_first};
    assign o_m_tuser  = r_out_sat;

endmodule

`default_nettype wire

@@ hdl/rpr_checker.sv @@
// ============================================================================
// rpr_checker - port-level checks for the pair rotator
// Watches the stream ports over time; bound to the top level.
// ============================================================================
`default_nettype none

module rpr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [63:0] i_s_tdata,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [63:0] o_m_tdata,
    input wire logic        o_m_tuser,
    input wire logic        i_cfg_we,
    input wire logic [1:0]  i_cfg_idx,
    input wire logic [21:0] i_cfg_data
);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output beat dropped or changed under stall");

    // an empty output slot never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with output slot empty");

    // a clamp flag comes with a value at a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[31:0] == 32'h7FFF_FFFF || o_m_tdata[31:0] == 32'h8000_0000 ||
            o_m_tdata[63:32] == 32'h7FFF_FFFF || o_m_tdata[63:32] == 32'h8000_0000)
        else $error("saturation flag without a clamped value");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind rope_pair_rotator rpr_checker u_rpr_checker (.*);

`default_nettype wire

@@ tb/sv/rope_pair_rotator_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rope_pair_rotator_tb - self-checking bench for the rotary pair rotator
// Streams fp16 pairs through the block under several register settings and
// idle patterns, predicts each rotated pair in fixed point and compares it
// field by field with the output beats in order.
// ============================================================================
`default_nettype none

module rope_pair_rotator_tb;

    localparam int  DRAIN_CYCLES = 100;
    localparam int  CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
        logic        sat;
    } t_rot;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = rpr_pkg::CFG_LOG2_BASE;
    logic [21:0] cfg_data = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire         m_tuser;

    rope_pair_rotator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    logic [63:0]     pair_queue[$];
    t_rot            rot_expect[$];
    int              errors = 0;
    int              cycles = 0;
    int              tx_idle = 0;
    int              rx_idle = 0;
    bit              s_took = 1'b0;
    logic [21:0]     sh_log2_base = rpr_pkg::RST_LOG2_BASE;
    logic [8:0]      sh_vec_len = rpr_pkg::RST_VEC_LEN;
    logic            sh_rope_en = rpr_pkg::RST_ROPE_EN;
    longint unsigned root_rom[1:16];

    // floor square root, one result bit at a time
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic longint half_to_fixed(input logic [15:0] h);
        longint mag;
        if (h[14:10] == 5'd0) mag = h[9:0];
        else if (h[14:10] == 5'd31) mag = longint'(32768) << 24;
        else mag = longint'(1024 + h[9:0]) << (h[14:10] - 1);
        return h[15] ? -mag : mag;
    endfunction

    function automatic logic [31:0] clamp32(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_rot rotate_pair(input logic [63:0] d);
        t_rot            r;
        longint          x, y, cx, cy, z, dx, dy, a, c, s, cs, sn;
        longint unsigned div, e, n, m, p;
        logic [127:0]    wide;
        logic [63:0]     hi;
        logic [31:0]     t;
        logic            sat;
        x = half_to_fixed(d[15:0]);
        y = half_to_fixed(d[31:16]);
        sat = 1'b0;
        if (!sh_rope_en) begin
            r.first  = clamp32((x + 128) >>> 8, sat);
            r.second = clamp32((y + 128) >>> 8, sat);
        end else begin
            div = (sh_vec_len == 0) ? 1 : sh_vec_len;
            e = (2 * longint'(d[38:32]) * longint'(sh_log2_base)) / div;
            n = e >> 16;
            m = 64'd1 << 32;
            for (int k = 1; k <= 16; k++)
                if (e[16-k]) m = (m * root_rom[k] + (64'd1 << 31)) >> 32;
            p = longint'(d[58:39]) * m;
            wide = {64'd0, p} * {66'd0, rpr_pkg::INV_TWO_PI_Q64};
            hi = wide[127:64];
            t = (n < 64) ? 32'(hi >> n) : 32'd0;
            z = longint'((64'(t[29:0]) * 64'(rpr_pkg::HALF_PI_Q30)) >> 30);
            cx = 652032874;
            cy = 0;
            for (int k = 0; k < 24; k++) begin
                a = (k < 11) ? longint'(rpr_pkg::ATAN_Q30[k]) : (longint'(1) << (30 - k));
                dx = cy >>> k;
                dy = cx >>> k;
                if (z >= 0) begin
                    cx = cx - dx; cy = cy + dy; z = z - a;
                end else begin
                    cx = cx + dx; cy = cy - dy; z = z + a;
                end
            end
            c = cx >>> 8;
            s = cy >>> 8;
            case (t[31:30])
                2'd0: begin cs = c;  sn = s;  end
                2'd1: begin cs = -s; sn = c;  end
                2'd2: begin cs = -c; sn = -s; end
                default: begin cs = s; sn = -c; end
            endcase
            r.first  = clamp32((x * cs - y * sn + (longint'(1) << 29)) >>> 30, sat);
            r.second = clamp32((y * cs + x * sn + (longint'(1) << 29)) >>> 30, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [63:0] pack_pair(input logic [15:0] xh, input logic [15:0] yh,
                                              input logic [6:0] idx, input logic [19:0] pos);
        return {5'd0, pos, idx, yh, xh};
    endfunction

    // mostly moderate magnitudes so the rotation is visible, some raw bit patterns
    function automatic logic [15:0] rand_half();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
    endfunction

    // sender: hold the beat until taken, then advance or idle
    always @(negedge i_clk) begin
        if (!s_tvalid || s_took) begin
            if (pair_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pair_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        t_rot got, want;
        cycles <= cycles + 1;
        s_took = i_rst_n && s_tvalid && s_tready;
        if (s_took) rot_expect.insert(rot_expect.size(), rotate_pair(s_tdata));
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tuser};
            if (rot_expect.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, actual %h", $time, got);
            end else begin
                want = rot_expect.pop_front();
                if (got.first !== want.first) begin
                    errors++;
                    $display("%0t: rotated_first expected %h actual %h",
                             $time, want.first, got.first);
                end
                if (got.second !== want.second) begin
                    errors++;
                    $display("%0t: rotated_second expected %h actual %h",
                             $time, want.second, got.second);
                end
                if (got.sat !== want.sat) begin
                    errors++;
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.sat, got.sat);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("rope_pair_rotator_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            rpr_pkg::CFG_LOG2_BASE: sh_log2_base = val;
            rpr_pkg::CFG_VEC_LEN:   sh_vec_len = val[8:0];
            default:                sh_rope_en = val[0];
        endcase
    endtask

    task automatic drain();
        while (pair_queue.size() != 0 || s_tvalid || rot_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_pair(input logic [63:0] d);
        pair_queue.insert(pair_queue.size(), d);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            add_pair(pack_pair(rand_half(), rand_half(),
                7'($urandom_range(0, 127)),
                ($urandom_range(0, 2) == 0) ? 20'($urandom_range(0, 64)) : 20'($urandom)));
    endtask

    initial begin
        logic [21:0] bases [8];
        logic [8:0]  dims  [8];
        logic        ens   [8];
        bases = '{22'd870805, 22'd0, 22'd2621440, 22'h3FFFFF, 22'd500000, 22'd1048576,
                  22'd870805, 22'd2621440};
        dims  = '{9'd128, 9'd2, 9'd256, 9'd0, 9'd3, 9'd511, 9'd64, 9'd256};
        ens   = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        root_rom[1] = floor_sqrt(64'h8000_0000 << 32);
        for (int k = 2; k <= 16; k++) root_rom[k] = floor_sqrt(root_rom[k-1] << 32);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: special encodings and field extremes at reset settings
        tx_idle = 30;
        rx_idle = 83;
        add_pair(pack_pair(16'h0000, 16'h8000, 7'd0, 20'd0));
        add_pair(pack_pair(16'h3C00, 16'h0000, 7'd0, 20'd1));
        add_pair(pack_pair(16'h3C00, 16'hBC00, 7'd1, 20'd100));
        add_pair(pack_pair(16'h7C00, 16'h3C00, 7'd5, 20'd7));
        add_pair(pack_pair(16'hFC00, 16'h0001, 7'd63, 20'hFFFFF));
        add_pair(pack_pair(16'h7E00, 16'hFFFF, 7'd127, 20'hFFFFF));
        add_pair(pack_pair(16'h7BFF, 16'hFBFF, 7'd64, 20'd12345));
        add_pair(pack_pair(16'h0001, 16'h83FF, 7'd127, 20'd0));
        add_pair(pack_pair(16'h4800, 16'h4800, 7'd32, 20'h80000));
        add_pair(pack_pair(16'h5A00, 16'hDA00, 7'd2, 20'd3));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(rpr_pkg::CFG_LOG2_BASE, bases[ph]);
            write_reg(rpr_pkg::CFG_VEC_LEN, {13'd0, dims[ph]});
            write_reg(rpr_pkg::CFG_ROPE_EN, {21'd0, ens[ph]});
            tx_idle = (ph < 3) ? 30 : (ph < 6) ? 83 : 0;
            rx_idle = (ph < 3) ? 83 : (ph < 6) ? 30 : 0;
            push_random(118);
            // sender holds off until every result of this batch is back
            drain();
        end

        if (errors == 0) begin
            $display("rope_pair_rotator_tb: done, clean");
        end else begin
            $display("rope_pair_rotator_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ rope_pair_rotator.f @@
hdl/rpr_pkg.sv
hdl/rpr_cordic.sv
hdl/rope_pair_rotator.sv
hdl/rpr_checker.sv
tb/sv/rope_pair_rotator_tb.sv
